/* src/atab_pkg.sv */
// Shared types and constants for the ATA block-address to task-file unit.
`timescale 1ns / 1ps

package atab_pkg;

    // Addressing modes.
    localparam logic [1:0] MODE_CHS   = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;
    localparam logic [1:0] MODE_LBA48 = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ADDR_MODE    = 3'd0;
    localparam logic [2:0] CFG_TOTAL_BLOCKS = 3'd1;
    localparam logic [2:0] CFG_HEAD_COUNT   = 3'd2;
    localparam logic [2:0] CFG_SECTORS      = 3'd3;
    localparam logic [2:0] CFG_DRIVE_SELECT = 3'd4;

    // Task-file register selects.
    localparam logic [2:0] SEL_DRIVE_HEAD = 3'd0;
    localparam logic [2:0] SEL_SECT_COUNT = 3'd1;
    localparam logic [2:0] SEL_SECT_NUM   = 3'd2;
    localparam logic [2:0] SEL_CYL_LOW    = 3'd3;
    localparam logic [2:0] SEL_CYL_HIGH   = 3'd4;
    localparam logic [2:0] SEL_COMMAND    = 3'd5;

    // Command bytes: the extended (LBA-48) forms add CMD_EXT.
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_EXT   = 8'h04;

    // Drive/head register bits.
    localparam logic [7:0] DH_LBA   = 8'h40;
    localparam logic [7:0] DH_DRIVE = 8'h10;

    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned DIVISOR_W = 13;  // heads (5 bits) times sectors (8 bits)

    typedef struct packed {
        logic [1:0]        addr_mode;
        logic [ADDR_W-1:0] total_blocks;
        logic [4:0]        head_count;
        logic [7:0]        sectors_per_track;
        logic              drive_select;
    } t_cfg;

    typedef struct packed {
        logic              bad;
        logic              is_write;
        logic [ADDR_W-1:0] block_address;
    } t_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV_CYL,
        BK_DIV_HEAD,
        BK_EMIT
    } t_back_state;

endpackage

/* src/atab_front.sv */
// Front end: configuration registers and request classification.
`timescale 1ns / 1ps

module atab_front
    import atab_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_start,
    input  logic              i_full,
    input  logic              i_opcode,
    input  logic [ADDR_W-1:0] i_block_address,
    output t_cfg              o_cfg,
    output logic              o_push,
    output t_item             o_item
);

    t_cfg r_cfg;
    logic w_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.addr_mode         <= MODE_LBA28;
            r_cfg.total_blocks      <= '0;
            r_cfg.head_count        <= '0;
            r_cfg.sectors_per_track <= '0;
            r_cfg.drive_select      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ADDR_MODE:    r_cfg.addr_mode         <= i_cfg_data[1:0];
                CFG_TOTAL_BLOCKS: r_cfg.total_blocks      <= i_cfg_data;
                CFG_HEAD_COUNT:   r_cfg.head_count        <= i_cfg_data[4:0];
                CFG_SECTORS:      r_cfg.sectors_per_track <= i_cfg_data[7:0];
                CFG_DRIVE_SELECT: r_cfg.drive_select      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // An undefined mode, a zero CHS geometry or an address past capacity is rejected.
    always_comb begin
        w_bad = (i_block_address >= r_cfg.total_blocks) || (r_cfg.addr_mode > MODE_LBA48);
        if (r_cfg.addr_mode == MODE_CHS &&
            (r_cfg.head_count == 5'd0 || r_cfg.sectors_per_track == 8'd0)) begin
            w_bad = 1'b1;
        end
    end

    assign o_cfg                = r_cfg;
    assign o_push               = i_start && !i_full;
    assign o_item.bad           = w_bad;
    assign o_item.is_write      = i_opcode;
    assign o_item.block_address = i_block_address;

endmodule

/* src/atab_queue.sv */
// Small FIFO of classified requests between the front and back ends.
`timescale 1ns / 1ps

module atab_queue
    import atab_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_item o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

/* src/atab_back.sv */
// Back end: CHS divider and the task-file write sequencer.
`timescale 1ns / 1ps

module atab_back
    import atab_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_pop,
    output logic       o_result_valid,
    output logic [2:0] o_reg_select,
    output logic [7:0] o_reg_value,
    output logic       o_last_write,
    output logic       o_addr_error
);

    t_back_state r_state;
    t_back_state n_state;

    logic                 r_bad;
    logic                 r_write;
    logic [ADDR_W-1:0]    r_ba;
    logic [3:0]           r_head;
    logic [7:0]           r_sect;
    logic [15:0]          r_cyl;
    logic [3:0]           r_beat;
    logic [ADDR_W-1:0]    r_dvd;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_dvs;
    logic [15:0]          r_quo;
    logic [5:0]           r_cnt;

    logic                 r_out_valid;
    logic [2:0]           r_out_sel;
    logic [7:0]           r_out_val;
    logic                 r_out_last;
    logic                 r_out_err;

    logic                 w_chs;
    logic                 w_lba48;
    logic                 w_last;
    logic                 w_load;
    logic [DIVISOR_W:0]   w_trial;
    logic                 w_ge;
    logic [DIVISOR_W-1:0] w_rem_nx;
    logic [3:0]           w_slot;
    logic [7:0]           w_b0;
    logic [7:0]           w_b1;
    logic [7:0]           w_b2;
    logic [2:0]           w_sel;
    logic [7:0]           w_val;

    assign w_chs   = (i_cfg.addr_mode == MODE_CHS);
    assign w_lba48 = (i_cfg.addr_mode == MODE_LBA48);
    assign w_last  = r_bad || (r_beat == (w_lba48 ? 4'd9 : 4'd5));
    assign w_load  = i_q_valid &&
                     ((r_state == BK_IDLE) || (r_state == BK_EMIT && w_last));
    assign o_pop   = w_load;

    // One restoring division step per cycle.
    assign w_trial  = {r_rem, r_dvd[ADDR_W-1]};
    assign w_ge     = (w_trial >= {1'b0, r_dvs});
    assign w_rem_nx = w_ge ? DIVISOR_W'(w_trial - {1'b0, r_dvs}) : w_trial[DIVISOR_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (w_load) begin
                    n_state = (!i_q_item.bad && w_chs) ? BK_DIV_CYL : BK_EMIT;
                end
            end
            BK_DIV_CYL: begin
                if (r_cnt == 6'd0) begin
                    n_state = BK_DIV_HEAD;
                end
            end
            BK_DIV_HEAD: begin
                if (r_cnt == 6'd0) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_load) begin
                    n_state = (!i_q_item.bad && w_chs) ? BK_DIV_CYL : BK_EMIT;
                end else if (w_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Beat contents. Outside LBA-48 the four high-order writes are skipped.
    always_comb begin
        w_slot = (!w_lba48 && r_beat != 4'd0) ? r_beat + 4'd4 : r_beat;
        w_b0   = w_chs ? r_sect      : r_ba[7:0];
        w_b1   = w_chs ? r_cyl[7:0]  : r_ba[15:8];
        w_b2   = w_chs ? r_cyl[15:8] : r_ba[23:16];
        w_sel  = SEL_DRIVE_HEAD;
        w_val  = 8'h00;
        if (!r_bad) begin
            unique case (w_slot)
                4'd0: begin
                    w_sel = SEL_DRIVE_HEAD;
                    w_val = (i_cfg.drive_select ? DH_DRIVE : 8'h00) |
                            (w_chs ? 8'h00 : DH_LBA) | {4'h0, r_head};
                end
                4'd1: begin
                    w_sel = SEL_SECT_COUNT;
                    w_val = 8'h00;
                end
                4'd2: begin
                    w_sel = SEL_SECT_NUM;
                    w_val = r_ba[31:24];
                end
                4'd3: begin
                    w_sel = SEL_CYL_LOW;
                    w_val = r_ba[39:32];
                end
                4'd4: begin
                    w_sel = SEL_CYL_HIGH;
                    w_val = r_ba[47:40];
                end
                4'd5: begin
                    w_sel = SEL_SECT_COUNT;
                    w_val = 8'h01;
                end
                4'd6: begin
                    w_sel = SEL_SECT_NUM;
                    w_val = w_b0;
                end
                4'd7: begin
                    w_sel = SEL_CYL_LOW;
                    w_val = w_b1;
                end
                4'd8: begin
                    w_sel = SEL_CYL_HIGH;
                    w_val = w_b2;
                end
                4'd9: begin
                    w_sel = SEL_COMMAND;
                    w_val = (r_write ? CMD_WRITE : CMD_READ) | (w_lba48 ? CMD_EXT : 8'h00);
                end
                default: begin
                    w_sel = SEL_DRIVE_HEAD;
                    w_val = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == BK_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sel  <= w_sel;
        r_out_val  <= w_val;
        r_out_last <= w_last;
        r_out_err  <= r_bad;

        if (w_load) begin
            r_bad   <= i_q_item.bad;
            r_write <= i_q_item.is_write;
            r_ba    <= i_q_item.block_address;
            r_beat  <= 4'd0;
            r_dvd   <= i_q_item.block_address;
            r_rem   <= '0;
            r_dvs   <= DIVISOR_W'(i_cfg.head_count) * DIVISOR_W'(i_cfg.sectors_per_track);
            r_cnt   <= 6'(ADDR_W - 1);
            r_head  <= (i_cfg.addr_mode == MODE_LBA28) ? i_q_item.block_address[27:24] : 4'h0;
        end else begin
            unique case (r_state)
                BK_DIV_CYL: begin
                    r_quo <= {r_quo[14:0], w_ge};
                    if (r_cnt == 6'd0) begin
                        // Cylinder done; divide the remainder by sectors per track.
                        r_cyl <= {r_quo[14:0], w_ge};
                        r_dvd <= {w_rem_nx, (ADDR_W - DIVISOR_W)'(0)};
                        r_rem <= '0;
                        r_dvs <= {(DIVISOR_W - 8)'(0), i_cfg.sectors_per_track};
                        r_cnt <= 6'(DIVISOR_W - 1);
                    end else begin
                        r_rem <= w_rem_nx;
                        r_dvd <= {r_dvd[ADDR_W-2:0], 1'b0};
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                BK_DIV_HEAD: begin
                    r_rem <= w_rem_nx;
                    r_dvd <= {r_dvd[ADDR_W-2:0], 1'b0};
                    r_quo <= {r_quo[14:0], w_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_head <= {r_quo[2:0], w_ge};
                        r_sect <= w_rem_nx[7:0] + 8'd1;
                    end
                end
                BK_EMIT: begin
                    r_beat <= r_beat + 4'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_reg_select   = r_out_sel;
    assign o_reg_value    = r_out_val;
    assign o_last_write   = r_out_last;
    assign o_addr_error   = r_out_err;

endmodule

/* src/ata_block_address_to_taskfile_unit.sv */
// Top level of the ATA block-address to task-file unit.
`timescale 1ns / 1ps

// Usage:
// A request (i_opcode, i_block_address) is taken at a clock edge where i_start is
// high and o_busy is low. Each request yields a run of task-file writes on
// o_reg_select / o_reg_value, one beat per cycle marked by o_result_valid, with
// o_last_write on the final beat. A rejected request gives a single beat with
// o_addr_error set. The receiver cannot stall: every beat is valid for one cycle.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the user
// must do so only while no request is pending, as the block does not enforce it.
// Indexes beyond the register list are ignored. In LBA modes the first beat
// follows once the back end has loaded the request from the queue; in CHS mode
// the bit-serial divider runs first, 48 steps for the cylinder and 13 for head
// and sector. The sequencer emits one beat per cycle and starts the next queued
// request right after a last beat, so a request gives 10 writes in LBA-48 and
// 6 in LBA-28 or CHS. A small request queue lets the front accept while the
// back is still working; o_busy is high while it is full.
// Reset restores LBA-28 mode with zero capacity, so every request is rejected
// until capacity is written.

module ata_block_address_to_taskfile_unit
    import atab_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_opcode,
    input  logic [ADDR_W-1:0] i_block_address,
    output logic              o_result_valid,
    output logic [2:0]        o_reg_select,
    output logic [7:0]        o_reg_value,
    output logic              o_last_write,
    output logic              o_addr_error
);

    t_cfg  w_cfg;
    t_item w_push_item;
    t_item w_head_item;
    logic  w_push;
    logic  w_pop;
    logic  w_q_valid;
    logic  w_q_full;

    atab_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start         (i_start),
        .i_full          (w_q_full),
        .i_opcode        (i_opcode),
        .i_block_address (i_block_address),
        .o_cfg           (w_cfg),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    atab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_head_item)
    );

    atab_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_head_item),
        .o_pop          (w_pop),
        .o_result_valid (o_result_valid),
        .o_reg_select   (o_reg_select),
        .o_reg_value    (o_reg_value),
        .o_last_write   (o_last_write),
        .o_addr_error   (o_addr_error)
    );

    assign o_busy = w_q_full;

endmodule
